/* hw/rtl/afskm_pkg.sv */
// afskm_pkg: shared types, register indexes and cosine table builder
// for the afsk continuous-phase modulator; no dependencies
`default_nettype none

package afskm_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_AVG,
    S_STEP,
    S_LOAD
  } seq_state_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BYTE_MODE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LSB_FIRST = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLES_PER_BIT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_INC = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_INC = 3'd4;

  localparam int unsigned SPB_BITS = 7;
  localparam int unsigned DATA_BITS = 8;

  // pi/2 in q30 and the taylor term divisors (2n-1)*2n
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned TERM_DIV [6] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132};

  // quarter-wave cosine entry r, evaluated at elaboration only
  function automatic longint unsigned cos_entry(input int unsigned r,
                                                input int unsigned addr_bits,
                                                input int unsigned sample_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned amp;
    longint sum;
    int n;
    x = (longint'(r) * HALF_PI_Q30) >> (addr_bits - 2);
    x2 = (x * x) >> 30;
    term = ONE_Q30;
    sum = longint'(ONE_Q30);
    for (n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / TERM_DIV[n-1];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    amp = (64'd1 << (sample_bits - 1)) - 64'd1;
    return (longint'(sum) * amp + (64'd1 << 29)) >> 30;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/afskm_cos_rom.sv */
// afskm_cos_rom: quarter-wave cosine table with registered read port
// uses afskm_pkg::cos_entry for its contents
`default_nettype none

module afskm_cos_rom #(
  parameter int unsigned ADDR_BITS = 9,
  parameter int unsigned ENTRY_BITS = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_BITS-1:0]  rd_addr,
  output logic      [ENTRY_BITS-1:0] rd_data
);

  // entries 0..quarter inclusive
  localparam int unsigned DEPTH = (1 << (ADDR_BITS - 1)) + 1;

  logic [ENTRY_BITS-1:0] table_w [DEPTH];
  logic [ENTRY_BITS-1:0] rd_data_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_tab
    assign table_w[g] = ENTRY_BITS'(afskm_pkg::cos_entry(g, ADDR_BITS + 1, ENTRY_BITS + 1));
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= table_w[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hw/rtl/afsk_continuous_phase_modulator_top.sv */
// flow: the item is taken in idle; each bit starts with avg, then each of its samples
//   passes step and load, which fills the output register; a new item is taken only in
//   idle, once the item's last sample is loaded; an item is 8 bits in byte mode or 1 in bit mode
// the sequencer shares a single phase adder and uses a registered cosine read; output stalls hold the load state
// reset: synchronous active-low rst_n clears phase, previous bit, sequencer and
//   output valid, and loads the register defaults
`default_nettype none

module afsk_continuous_phase_modulator_top #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_SAMPLES_PER_BIT = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // input item channel
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [afskm_pkg::DATA_BITS-1:0]         in_data_in,
  // result item channel
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [SAMPLE_BITS-1:0]                out_sample,
  output logic                                         out_last_of_item,
  // configuration write channel
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [afskm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [afskm_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int unsigned PB = PHASE_BITS;
  localparam int unsigned QW = TABLE_ADDR_BITS - 2;   // quarter offset width
  localparam int unsigned RW = TABLE_ADDR_BITS - 1;   // table address width
  localparam int unsigned EW = SAMPLE_BITS - 1;       // table entry width
  localparam int unsigned SW = (MAX_SAMPLES_PER_BIT > 1) ? $clog2(MAX_SAMPLES_PER_BIT) : 1;
  localparam int unsigned CAP_BYTE = (MAX_SAMPLES_PER_BIT < 8) ? MAX_SAMPLES_PER_BIT : 8;
  localparam logic [RW-1:0] QUARTER_ADDR = RW'(1 << QW);
  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration registers
  logic                              byte_mode_r;
  logic                              lsb_first_r;
  logic [afskm_pkg::SPB_BITS-1:0]    spb_r;
  logic [afskm_pkg::CFG_DATA_BITS-1:0] zero_inc_r;
  logic [afskm_pkg::CFG_DATA_BITS-1:0] one_inc_r;

  // sequencer and datapath state
  afskm_pkg::seq_state_t             state_r, state_nxt;
  logic [PB-1:0]                     phase_r, phase_nxt;
  logic [PB-1:0]                     inc_r, inc_nxt;
  logic                              prev_bit_r, prev_bit_nxt;
  logic [afskm_pkg::DATA_BITS-1:0]   data_r, data_nxt;
  logic [2:0]                        bit_idx_r, bit_idx_nxt;
  logic [SW-1:0]                     samp_r, samp_nxt;
  logic [SW-1:0]                     spb_last_r, spb_last_nxt;
  logic                              neg_r, neg_nxt;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]            out_sample_r, out_sample_nxt;
  logic                              out_last_r, out_last_nxt;

  // combinational helpers
  logic                              in_acc;
  logic                              cur_bit;
  logic [PB-1:0]                     zi, oi, cur_inc, prev_inc;
  logic [PB-1:0]                     op_a, op_b, add_sum;
  logic                              add_cin;
  logic [TABLE_ADDR_BITS-1:0]        tab_idx;
  logic [RW-1:0]                     rom_addr;
  logic [EW-1:0]                     rom_data;
  logic                              rom_en;
  logic                              last_samp, last_bit, load_ok;
  logic [afskm_pkg::SPB_BITS-1:0]    spb_eff, spb_cap;

  assign in_ready = (state_r == afskm_pkg::S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // increments masked to the phase width
  assign zi = PB'(zero_inc_r);
  assign oi = PB'(one_inc_r);

  // bit under work: msb first, lsb first, or bit 0 in bit mode
  always_comb begin
    if (!byte_mode_r) begin
      cur_bit = data_r[0];
    end else if (lsb_first_r) begin
      cur_bit = data_r[bit_idx_r];
    end else begin
      cur_bit = data_r[3'd7 - bit_idx_r];
    end
  end

  assign cur_inc = cur_bit ? oi : zi;
  assign prev_inc = prev_bit_r ? oi : zi;

  // shared adder: floor average of increments at bit start, phase step otherwise
  always_comb begin
    if (state_r == afskm_pkg::S_AVG) begin
      op_a = prev_inc >> 1;
      op_b = cur_inc >> 1;
      add_cin = prev_inc[0] & cur_inc[0];
    end else begin
      op_a = phase_r;
      op_b = inc_r;
      add_cin = 1'b0;
    end
  end

  assign add_sum = op_a + op_b + PB'(add_cin);

  // table address from the new phase, folded by quadrant
  assign tab_idx = add_sum[PB-1 -: TABLE_ADDR_BITS];
  assign rom_addr = tab_idx[TABLE_ADDR_BITS-2] ?
                    (QUARTER_ADDR - RW'(tab_idx[QW-1:0])) : RW'(tab_idx[QW-1:0]);
  assign rom_en = (state_r == afskm_pkg::S_STEP);

  afskm_cos_rom #(
    .ADDR_BITS  (RW),
    .ENTRY_BITS (EW)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rom_en),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // samples per bit: zero means one, capped at 8 in byte mode and at MAX_SAMPLES_PER_BIT in bit mode
  always_comb begin
    spb_cap = byte_mode_r ? afskm_pkg::SPB_BITS'(CAP_BYTE)
                          : afskm_pkg::SPB_BITS'(MAX_SAMPLES_PER_BIT);
    spb_eff = (spb_r == '0) ? afskm_pkg::SPB_BITS'(1) : spb_r;
    if (spb_eff > spb_cap) begin
      spb_eff = spb_cap;
    end
  end

  assign last_samp = (samp_r == spb_last_r);
  assign last_bit = !byte_mode_r || (bit_idx_r == 3'd7);
  assign load_ok = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      afskm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = afskm_pkg::S_AVG;
        end
      end
      afskm_pkg::S_AVG: begin
        state_nxt = afskm_pkg::S_STEP;
      end
      afskm_pkg::S_STEP: begin
        state_nxt = afskm_pkg::S_LOAD;
      end
      afskm_pkg::S_LOAD: begin
        if (load_ok) begin
          if (!last_samp) begin
            state_nxt = afskm_pkg::S_STEP;
          end else if (last_bit) begin
            state_nxt = afskm_pkg::S_IDLE;
          end else begin
            state_nxt = afskm_pkg::S_AVG;
          end
        end
      end
      default: begin
        state_nxt = afskm_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and output register updates
  always_comb begin
    phase_nxt = phase_r;
    inc_nxt = inc_r;
    prev_bit_nxt = prev_bit_r;
    data_nxt = data_r;
    bit_idx_nxt = bit_idx_r;
    samp_nxt = samp_r;
    spb_last_nxt = spb_last_r;
    neg_nxt = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      afskm_pkg::S_IDLE: begin
        if (in_acc) begin
          data_nxt = in_data_in;
          bit_idx_nxt = '0;
          samp_nxt = '0;
          spb_last_nxt = SW'(spb_eff - afskm_pkg::SPB_BITS'(1));
        end
      end
      afskm_pkg::S_AVG: begin
        inc_nxt = add_sum;
      end
      afskm_pkg::S_STEP: begin
        phase_nxt = add_sum;
        inc_nxt = cur_inc;
        // quadrants 1 and 2 negate
        neg_nxt = tab_idx[TABLE_ADDR_BITS-1] ^ tab_idx[TABLE_ADDR_BITS-2];
      end
      afskm_pkg::S_LOAD: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_sample_nxt = neg_r ? (SAMPLE_BITS'(0) - {1'b0, rom_data}) : {1'b0, rom_data};
          out_last_nxt = last_samp && last_bit;
          if (last_samp) begin
            prev_bit_nxt = cur_bit;
            samp_nxt = '0;
            bit_idx_nxt = bit_idx_r + 3'd1;
          end else begin
            samp_nxt = samp_r + SW'(1);
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r;
      end
    endcase
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= afskm_pkg::S_IDLE;
      phase_r <= '0;
      prev_bit_r <= 1'b0;
      out_valid_r <= 1'b0;
      bit_idx_r <= '0;
      samp_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      prev_bit_r <= prev_bit_nxt;
      out_valid_r <= out_valid_nxt;
      bit_idx_r <= bit_idx_nxt;
      samp_r <= samp_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    inc_r <= inc_nxt;
    data_r <= data_nxt;
    spb_last_r <= spb_last_nxt;
    neg_r <= neg_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r <= out_last_nxt;
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_mode_r <= 1'b1;
      lsb_first_r <= 1'b0;
      spb_r <= afskm_pkg::SPB_BITS'(8);
      zero_inc_r <= 32'd984263339;
      one_inc_r <= 32'd536870912;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        afskm_pkg::CFG_BYTE_MODE:       byte_mode_r <= cfg_data[0];
        afskm_pkg::CFG_LSB_FIRST:       lsb_first_r <= cfg_data[0];
        afskm_pkg::CFG_SAMPLES_PER_BIT: spb_r <= cfg_data[afskm_pkg::SPB_BITS-1:0];
        afskm_pkg::CFG_ZERO_INC:        zero_inc_r <= cfg_data;
        afskm_pkg::CFG_ONE_INC:         one_inc_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last_of_item = out_last_r;

`ifndef ASSERT_OFF
  // sample counter never runs past the bit's last sample
  a_samp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != afskm_pkg::S_IDLE) |-> (samp_r <= spb_last_r))
    else $error("sample counter beyond samples per bit");

  // bit mode sends exactly one bit
  a_bit_mode_one: assert property (@(posedge clk) disable iff (!rst_n)
    (!byte_mode_r && state_r != afskm_pkg::S_IDLE) |-> (bit_idx_r == 3'd0))
    else $error("bit index moved in bit mode");

  // phase advances only in the step state
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != afskm_pkg::S_STEP) |=> $stable(phase_r))
    else $error("phase changed outside step");

  // samples stay inside the symmetric range
  a_no_most_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sample_r != MOST_NEG))
    else $error("sample at most negative code");
`endif

endmodule

`default_nettype wire

/* sim/afsk_continuous_phase_modulator_top_tb.sv */
// afsk_continuous_phase_modulator_top_tb: self-checking bench for the afsk modulator,
// with a cycle-free sample predictor, a directed table and randomized phases
// depends on afskm_pkg and afsk_continuous_phase_modulator_top
`default_nettype none

module afsk_continuous_phase_modulator_top_tb;

  // widths and register indexes from the package
  localparam int unsigned CFG_IDX_BITS  = afskm_pkg::CFG_IDX_BITS;
  localparam int unsigned CFG_DATA_BITS = afskm_pkg::CFG_DATA_BITS;
  localparam int unsigned DATA_BITS     = afskm_pkg::DATA_BITS;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BYTE_MODE       = afskm_pkg::CFG_BYTE_MODE;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LSB_FIRST       = afskm_pkg::CFG_LSB_FIRST;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLES_PER_BIT = afskm_pkg::CFG_SAMPLES_PER_BIT;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_INC        = afskm_pkg::CFG_ZERO_INC;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_INC         = afskm_pkg::CFG_ONE_INC;

  // bench timing
  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int PHASE_COUNT    = 6;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int MAX_REPORTS    = 10;

  // predictor geometry, matches the default parameters of the block
  localparam int MAX_SPB       = 64;
  localparam int BYTE_SPB_CAP  = 8;
  localparam int QUARTER_LEN   = 256;    // quarter wave of a 1024-entry table
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint unsigned PEAK_CODE        = 64'd32767;

  // configuration indexes that select no register
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_C = 3'd7;

  // register values after reset
  localparam logic [31:0] RESET_SPACE_STEP = 32'd984263339;
  localparam logic [31:0] RESET_MARK_STEP  = 32'd536870912;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } sample_rec_t;

  typedef enum logic [1:0] {
    ROW_CFG,    // register write, block idle
    ROW_ITEM,   // item checked against the predictor
    ROW_KNOWN   // item with its single sample typed in below
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] index;
    logic [31:0]             value;
    logic signed [15:0]      sample;
    logic                    last;
  } dir_row_t;

  localparam int NUM_ROWS = 38;

  // directed part: bit mode with one sample per bit first, so a phase of zero
  // can be steered to and its peak code read off directly
  dir_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_CFG,   CFG_BYTE_MODE,       32'hFFFF_FFFE, 16'sd0,     1'b0}, // upper bits masked
    '{ROW_CFG,   CFG_SAMPLES_PER_BIT, 32'hFFFF_FF81, 16'sd0,     1'b0}, // spb 1
    '{ROW_CFG,   CFG_ZERO_INC,        32'h0000_0000, 16'sd0,     1'b0},
    '{ROW_CFG,   CFG_ONE_INC,         32'h8000_0000, 16'sd0,     1'b0},
    // first bit after reset averages against the zero step
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_00FF, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_0001, 16'sd0,     1'b0},
    // quarter, three quarters, then a quarter more: back to phase zero
    '{ROW_KNOWN, CFG_BYTE_MODE,       32'h0000_0000, 16'sd32767, 1'b1},
    '{ROW_CFG,   CFG_ONE_INC,         32'h0000_0000, 16'sd0,     1'b0},
    // bits 7..1 ignored in bit mode
    '{ROW_KNOWN, CFG_BYTE_MODE,       32'h0000_00FE, 16'sd32767, 1'b1},
    '{ROW_CFG,   CFG_SPARE_A,         32'hFFFF_FFFF, 16'sd0,     1'b0},
    '{ROW_CFG,   CFG_SPARE_B,         32'hA5A5_A5A5, 16'sd0,     1'b0},
    '{ROW_CFG,   CFG_SPARE_C,         32'hFFFF_FFFF, 16'sd0,     1'b0},
    '{ROW_KNOWN, CFG_BYTE_MODE,       32'h0000_0001, 16'sd32767, 1'b1},
    '{ROW_CFG,   CFG_ZERO_INC,        32'hFFFF_FFFF, 16'sd0,     1'b0},
    '{ROW_CFG,   CFG_ONE_INC,         32'h8000_0000, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_0000, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_0001, 16'sd0,     1'b0},
    // spb zero runs as one
    '{ROW_CFG,   CFG_SAMPLES_PER_BIT, 32'h0000_0000, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_0055, 16'sd0,     1'b0},
    // spb above the cap saturates at 64 in bit mode
    '{ROW_CFG,   CFG_SAMPLES_PER_BIT, 32'h0000_007F, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_00AA, 16'sd0,     1'b0},
    '{ROW_CFG,   CFG_SAMPLES_PER_BIT, 32'h0000_0041, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_0001, 16'sd0,     1'b0},
    // byte mode clamps the same spb to 8
    '{ROW_CFG,   CFG_BYTE_MODE,       32'h0000_0001, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_0000, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_00FF, 16'sd0,     1'b0},
    '{ROW_CFG,   CFG_LSB_FIRST,       32'hFFFF_FFFF, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_0080, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_0001, 16'sd0,     1'b0},
    '{ROW_CFG,   CFG_SAMPLES_PER_BIT, 32'h0000_0001, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_00A5, 16'sd0,     1'b0},
    // back to the reset settings
    '{ROW_CFG,   CFG_LSB_FIRST,       32'h0000_0000, 16'sd0,     1'b0},
    '{ROW_CFG,   CFG_SAMPLES_PER_BIT, 32'h0000_0008, 16'sd0,     1'b0},
    '{ROW_CFG,   CFG_ZERO_INC,        RESET_SPACE_STEP, 16'sd0,  1'b0},
    '{ROW_CFG,   CFG_ONE_INC,         RESET_MARK_STEP,  16'sd0,  1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_0000, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_00FF, 16'sd0,     1'b0},
    '{ROW_ITEM,  CFG_BYTE_MODE,       32'h0000_005A, 16'sd0,     1'b0}
  };

  // dut ports, all inputs known from time zero
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [DATA_BITS-1:0]     in_data_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [15:0]       out_sample;
  logic                     out_last_of_item;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // predictor state: register shadows, phase and last sent bit
  logic        shadow_byte_mode;
  logic        shadow_lsb_first;
  logic [6:0]  shadow_spb;
  logic [31:0] shadow_space_step;
  logic [31:0] shadow_mark_step;
  logic [31:0] shadow_phase;
  logic        shadow_last_bit;
  logic signed [15:0] quarter_wave [0:QUARTER_LEN];

  sample_rec_t pending_samples [$];   // samples still owed by the block
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  afsk_continuous_phase_modulator_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_in       (in_data_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample       (out_sample),
    .out_last_of_item (out_last_of_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // one quarter-wave entry: taylor series in q30, clamped, scaled to q1.15
  function automatic logic signed [15:0] quarter_wave_entry(input int r);
    longint unsigned ru;
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint unsigned scaled;
    longint          acc;
    ru = 64'(r);
    angle = (ru * QUARTER_TURN_Q30) / QUARTER_LEN;
    angle_sq = (angle * angle) >> 30;
    term = 64'd1 << 30;
    acc = longint'(64'd1 << 30);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * angle_sq) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(64'd1 << 30)) begin
      acc = longint'(64'd1 << 30);
    end
    scaled = acc;
    scaled = (scaled * PEAK_CODE + (64'd1 << 29)) >> 30;
    return scaled[15:0];
  endfunction

  // full-wave cosine from the quarter table, top ten phase bits
  function automatic logic signed [15:0] cosine_at(input logic [31:0] ph);
    int r;
    r = int'(ph[29:22]);
    case (ph[31:30])
      2'd0: return quarter_wave[r];
      2'd1: return -quarter_wave[QUARTER_LEN - r];
      2'd2: return -quarter_wave[r];
      default: return quarter_wave[QUARTER_LEN - r];
    endcase
  endfunction

  // register write seen by the predictor
  function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                         input logic [31:0] value);
    case (idx)
      CFG_BYTE_MODE:       shadow_byte_mode = value[0];
      CFG_LSB_FIRST:       shadow_lsb_first = value[0];
      CFG_SAMPLES_PER_BIT: shadow_spb = value[6:0];
      CFG_ZERO_INC:        shadow_space_step = value;
      CFG_ONE_INC:         shadow_mark_step = value;
      default: ;
    endcase
  endfunction

  // append one sample to the owed list
  function automatic void owe_sample(input sample_rec_t rec);
    pending_samples.insert(pending_samples.size(), rec);
  endfunction

  // queue every sample one item produces, return how many
  function automatic int modulate_item(input logic [7:0] d);
    int          nbits;
    int          spb_cap;
    int          spb;
    int          count;
    logic        bit_val;
    logic [31:0] step;
    logic [31:0] prev_step;
    logic [31:0] first_step;
    sample_rec_t rec;
    nbits = shadow_byte_mode ? 8 : 1;
    spb_cap = shadow_byte_mode ? BYTE_SPB_CAP : MAX_SPB;
    spb = int'(shadow_spb);
    if (spb == 0) begin
      spb = 1;
    end
    if (spb > spb_cap) begin
      spb = spb_cap;
    end
    count = 0;
    for (int b = 0; b < nbits; b++) begin
      if (!shadow_byte_mode) begin
        bit_val = d[0];
      end else if (shadow_lsb_first) begin
        bit_val = d[b];
      end else begin
        bit_val = d[7 - b];
      end
      step = bit_val ? shadow_mark_step : shadow_space_step;
      prev_step = shadow_last_bit ? shadow_mark_step : shadow_space_step;
      // trapezoid step, floor of the mean without a carry out
      first_step = (prev_step >> 1) + (step >> 1) + {31'd0, prev_step[0] & step[0]};
      for (int s = 0; s < spb; s++) begin
        shadow_phase = shadow_phase + ((s == 0) ? first_step : step);
        rec.sample = cosine_at(shadow_phase);
        rec.last = (b == nbits - 1) && (s == spb - 1);
        owe_sample(rec);
        count++;
      end
      shadow_last_bit = bit_val;
    end
    return count;
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  // present one item, hold it until taken, then predict its samples
  task automatic send_item(input logic [7:0] d, input logic known, input sample_rec_t known_rec);
    int n;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_in <= d;
    do @(posedge clk); while (!in_ready);
    n = modulate_item(d);
    // typed rows replace the predicted sample with the one read off by hand
    if (known) begin
      repeat (n) void'(pending_samples.pop_back());
      owe_sample(known_rec);
    end
  endtask

  // drop valid and wait for every owed sample
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  // block idle and past its pipeline, safe for register writes
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver stalls at random, rate set per phase
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // sample checker, oldest expectation first
  always @(posedge clk) begin
    sample_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        note_failure($sformatf("unexpected sample %0d last %0d with nothing owed",
                               out_sample, out_last_of_item));
      end else begin
        want = pending_samples.pop_front();
        if (out_sample !== want.sample || out_last_of_item !== want.last) begin
          note_failure($sformatf("mismatch: sample exp %0d got %0d, last exp %0d got %0d",
                                 want.sample, out_sample, want.last, out_last_of_item));
        end
      end
    end
  end

  // watchdog on handshake activity of any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d samples owed",
               quiet_cycles, pending_samples.size());
      $display("afsk_continuous_phase_modulator_top regression: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] word;
    logic [31:0] spb_word;
    sample_rec_t known_rec;

    for (int r = 0; r <= QUARTER_LEN; r++) begin
      quarter_wave[r] = quarter_wave_entry(r);
    end
    shadow_byte_mode = 1'b1;
    shadow_lsb_first = 1'b0;
    shadow_spb = 7'd8;
    shadow_space_step = RESET_SPACE_STEP;
    shadow_mark_step = RESET_MARK_STEP;
    shadow_phase = '0;
    shadow_last_bit = 1'b0;

    // first stretch: sender mostly busy, receiver stalls often
    send_idle_pct = 19;
    recv_idle_pct = 52;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          settle();
          write_register(directed_rows[i].index, directed_rows[i].value);
        end
        ROW_KNOWN: begin
          known_rec.sample = directed_rows[i].sample;
          known_rec.last = directed_rows[i].last;
          send_item(directed_rows[i].value[7:0], 1'b1, known_rec);
        end
        default: begin
          send_item(directed_rows[i].value[7:0], 1'b0, '0);
        end
      endcase
    end

    // random phases: a fresh setting each, idling pattern changes every two
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      settle();
      // byte and bit mode alternate so each idling pattern sees both
      word = $urandom();
      word[0] = ~p[0];
      write_register(CFG_BYTE_MODE, word);
      write_register(CFG_LSB_FIRST, $urandom());
      // bit mode keeps items short most of the time
      spb_word = $urandom();
      if (!word[0] && $urandom_range(0, 7) != 0) begin
        spb_word[6:0] = 7'($urandom_range(0, 12));
      end
      write_register(CFG_SAMPLES_PER_BIT, spb_word);
      write_register(CFG_ZERO_INC, pick_step());
      write_register(CFG_ONE_INC, pick_step());
      write_register(CFG_IDX_BITS'($urandom_range(CFG_SPARE_A, CFG_SPARE_C)), $urandom());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sender holds off now and then until the block has emptied
        if (n == 10 || $urandom_range(0, 15) == 0) begin
          wait_drained();
        end
        send_item(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    // drain and let the pipeline run out
    wait_drained();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (pending_samples.size() != 0) begin
      note_failure($sformatf("%0d samples never arrived", pending_samples.size()));
    end
    if (mismatch_count == 0) begin
      $display("afsk_continuous_phase_modulator_top regression: pass");
    end else begin
      $display("afsk_continuous_phase_modulator_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
